### rtl/mersenne_twister_generator_unit_assert.svh
// Assertion macros used by the generator core.
`ifndef MERSENNE_TWISTER_GENERATOR_UNIT_ASSERT_SVH
`define MERSENNE_TWISTER_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTGEN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTGEN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mtgen_pkg.sv
// Package with constants, types and the sequencer states of the generator.
package mtgen_pkg;

    localparam int unsigned STATE_DEPTH  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned ADDR_W       = $clog2(STATE_DEPTH);
    localparam int unsigned IDX_W        = $clog2(STATE_DEPTH + 1);

    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

    typedef enum logic [2:0] {
        ST_SEED_START,
        ST_SEED_MUL,
        ST_SEED_WR,
        ST_IDLE,
        ST_TW_PRIME,
        ST_TW_READ,
        ST_TW_WRITE,
        ST_DRAW_DATA
    } mtgen_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              rd_a_en;
        logic [ADDR_W-1:0] rd_a_addr;
        logic              rd_b_en;
        logic [ADDR_W-1:0] rd_b_addr;
    } mtgen_mem_ctl_t;

endpackage

### rtl/mtgen_ram.sv
// State word memory with one write port and two registered read ports.
module mtgen_ram
    import mtgen_pkg::*;
(
    input  logic                 clk,
    input  mtgen_mem_ctl_t       ctl,
    input  logic [WORD_W-1:0]    wdata,
    output logic [WORD_W-1:0]    rd_a,
    output logic [WORD_W-1:0]    rd_b
);

    logic [WORD_W-1:0] mem [STATE_DEPTH];
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_a_en)
        begin
            rd_a_reg <= mem[ctl.rd_a_addr];
        end
        if (ctl.rd_b_en)
        begin
            rd_b_reg <= mem[ctl.rd_b_addr];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

### rtl/mtgen_core.sv
// Sequencer and shared datapath for seeding, twisting, tempering and bounded draws.
`include "mersenne_twister_generator_unit_assert.svh"

module mtgen_core
    import mtgen_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [WORD_W-1:0]    cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_opcode,
    input  logic [WORD_W-1:0]    in_bound,
    input  logic                 res_ready,
    output logic                 res_valid,
    output logic [WORD_W-1:0]    res_value,
    output mtgen_mem_ctl_t       mem_ctl,
    output logic [WORD_W-1:0]    mem_wdata,
    input  logic [WORD_W-1:0]    mem_rd_a,
    input  logic [WORD_W-1:0]    mem_rd_b
);

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [WORD_W-1:0] smear(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        y = x | (x >> 1);
        y = y | (y >> 2);
        y = y | (y >> 4);
        y = y | (y >> 8);
        y = y | (y >> 16);
        return y;
    endfunction

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_DEPTH - 1);
    localparam logic [IDX_W-1:0]  IDX_END   = IDX_W'(STATE_DEPTH);

    mtgen_state_t       state_reg, state_next;
    logic [WORD_W-1:0]  seed_reg, seed_next;
    logic [ADDR_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [WORD_W-1:0]  prev_reg, prev_next;
    logic [WORD_W-1:0]  prod_reg, prod_next;
    logic [WORD_W-1:0]  cur_reg, cur_next;
    logic [WORD_W-1:0]  bound_reg, bound_next;
    logic [WORD_W-1:0]  mask_reg, mask_next;
    logic               op_reg, op_next;

    logic [WORD_W-1:0]  seed_word;
    logic [WORD_W-1:0]  mix_word;
    logic [WORD_W-1:0]  twist_word;
    logic [WORD_W-1:0]  tempered;
    logic [WORD_W-1:0]  draw_value;
    logic               draw_ok;
    logic [ADDR_W:0]    off_sum;
    logic [ADDR_W-1:0]  off_addr;
    logic [ADDR_W-1:0]  nxt_addr;

    always_comb
    begin
        seed_word  = prod_reg + WORD_W'(k_reg);
        mix_word   = {cur_reg[WORD_W-1], mem_rd_a[WORD_W-2:0]};
        twist_word = mem_rd_b ^ (mix_word >> 1) ^ (mem_rd_a[0] ? TWIST_MATRIX : '0);
        tempered   = temper(mem_rd_a);
        draw_value = op_reg ? (tempered & mask_reg) : tempered;
        draw_ok    = !op_reg || (draw_value <= bound_reg);
        off_sum    = {1'b0, k_reg} + (ADDR_W + 1)'(TWIST_OFFSET);
        if (off_sum >= (ADDR_W + 1)'(STATE_DEPTH))
        begin
            off_sum = off_sum - (ADDR_W + 1)'(STATE_DEPTH);
        end
        off_addr   = off_sum[ADDR_W-1:0];
        nxt_addr   = (k_reg == LAST_ADDR) ? '0 : k_reg + ADDR_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        seed_next  = seed_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        prev_next  = prev_reg;
        prod_next  = prod_reg;
        cur_next   = cur_reg;
        bound_next = bound_reg;
        mask_next  = mask_reg;
        op_next    = op_reg;
        mem_ctl    = '0;
        mem_wdata  = seed_word;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        res_value  = draw_value;

        case (state_reg)
            ST_SEED_START:
            begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = '0;
                mem_wdata     = seed_reg;
                prev_next     = seed_reg;
                k_next        = ADDR_W'(1);
                state_next    = ST_SEED_MUL;
            end
            ST_SEED_MUL:
            begin
                prod_next  = SEED_MULT * (prev_reg ^ (prev_reg >> 30));
                state_next = ST_SEED_WR;
            end
            ST_SEED_WR:
            begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = k_reg;
                mem_wdata     = seed_word;
                prev_next     = seed_word;
                if (k_reg == LAST_ADDR)
                begin
                    idx_next   = IDX_END;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = ST_SEED_MUL;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = in_opcode;
                    bound_next = in_bound;
                    mask_next  = smear(in_bound);
                    if (idx_reg >= IDX_END)
                    begin
                        state_next = ST_TW_PRIME;
                    end
                    else
                    begin
                        mem_ctl.rd_a_en   = 1'b1;
                        mem_ctl.rd_a_addr = idx_reg[ADDR_W-1:0];
                        idx_next          = idx_reg + IDX_W'(1);
                        state_next        = ST_DRAW_DATA;
                    end
                end
            end
            ST_TW_PRIME:
            begin
                mem_ctl.rd_a_en   = 1'b1;
                mem_ctl.rd_a_addr = '0;
                k_next            = '0;
                state_next        = ST_TW_READ;
            end
            ST_TW_READ:
            begin
                cur_next          = mem_rd_a;
                mem_ctl.rd_a_en   = 1'b1;
                mem_ctl.rd_a_addr = nxt_addr;
                mem_ctl.rd_b_en   = 1'b1;
                mem_ctl.rd_b_addr = off_addr;
                state_next        = ST_TW_WRITE;
            end
            ST_TW_WRITE:
            begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = k_reg;
                mem_wdata     = twist_word;
                if (k_reg == LAST_ADDR)
                begin
                    mem_ctl.rd_a_en   = 1'b1;
                    mem_ctl.rd_a_addr = '0;
                    idx_next          = IDX_W'(1);
                    state_next        = ST_DRAW_DATA;
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = ST_TW_READ;
                end
            end
            ST_DRAW_DATA:
            begin
                if (draw_ok)
                begin
                    if (res_ready)
                    begin
                        res_valid  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg >= IDX_END)
                begin
                    state_next = ST_TW_PRIME;
                end
                else
                begin
                    mem_ctl.rd_a_en   = 1'b1;
                    mem_ctl.rd_a_addr = idx_reg[ADDR_W-1:0];
                    idx_next          = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_SEED_START;
            end
        endcase

        if (cfg_we)
        begin
            seed_next  = cfg_wdata;
            idx_next   = IDX_END;
            state_next = ST_SEED_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SEED_START;
            seed_reg  <= SEED_RESET;
            k_reg     <= '0;
            idx_reg   <= IDX_END;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg  <= seed_next;
            k_reg     <= k_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        prod_reg  <= prod_next;
        cur_reg   <= cur_next;
        bound_reg <= bound_next;
        mask_reg  <= mask_next;
        op_reg    <= op_next;
    end

    `MTGEN_ASSERT_SAME(a_no_write_idle, clk, rst_n, state_reg == ST_IDLE, !mem_ctl.we,
        "State memory written while idle.")
    `MTGEN_ASSERT_SAME(a_idx_range, clk, rst_n, 1'b1, idx_reg <= IDX_END,
        "Read index beyond the state depth.")
    `MTGEN_ASSERT_SAME(a_bounded_result, clk, rst_n, res_valid && op_reg,
        res_value <= bound_reg, "Bounded result above its bound.")
    `MTGEN_ASSERT_NEXT(a_twist_first, clk, rst_n,
        in_valid && in_ready && (idx_reg == IDX_END) && !cfg_we,
        state_reg == ST_TW_PRIME, "Exhausted state not regenerated before a draw.")

endmodule

### rtl/mersenne_twister_generator_unit.sv
// Top level of the MT19937 generator: core, state memory and output register.
//
// Channel   Direction  Signals                       Payload (lowest bits first)
// s_*       in         s_tvalid s_tready s_tdata     tdata: bound; tuser: opcode
// m_*       out        m_tvalid m_tready m_tdata     tdata: value
// cfg_*     in         cfg_we cfg_wdata              seed
//
// A draw reads its word through the registered read port and then loads the output
// register; each redraw of a bounded request issues another read through the single
// read port used for draws. Every 624 words the state is regenerated in place, each
// word read and then rewritten. After reset and after every seed write the memory
// is seeded through the multiplier; no transaction is accepted meanwhile.
// A request is accepted while a finished result still waits in the output register.
module mersenne_twister_generator_unit
    import mtgen_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [WORD_W-1:0]    cfg_wdata,   // seed
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_W-1:0]    s_tdata,     // bound
    input  logic                 s_tuser,     // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [WORD_W-1:0]    m_tdata      // value
);

    mtgen_mem_ctl_t     mem_ctl;
    logic [WORD_W-1:0]  mem_wdata;
    logic [WORD_W-1:0]  mem_rd_a;
    logic [WORD_W-1:0]  mem_rd_b;
    logic               res_ready;
    logic               res_valid;
    logic [WORD_W-1:0]  res_value;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_data_reg;

    mtgen_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .in_bound  (s_tdata),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_value (res_value),
        .mem_ctl   (mem_ctl),
        .mem_wdata (mem_wdata),
        .mem_rd_a  (mem_rd_a),
        .mem_rd_b  (mem_rd_b)
    );

    mtgen_ram u_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .wdata (mem_wdata),
        .rd_a  (mem_rd_a),
        .rd_b  (mem_rd_b)
    );

    always_comb
    begin
        res_ready      = !out_valid_reg || m_tready;
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
